// ===== hw/rtl/ndef_rsp_pkg.sv =====
// Shared types and constants for the NDEF record stream parser.
// Holds the phase and result-kind codes and the result payload struct.
// It has no dependencies. The output interface, parser, top level and checker import it.
package ndef_rsp_pkg;

  // Reset value of the prefix skip register.
  localparam logic [3:0] PREFIX_SKIP_RST = 4'd2;

  // Bit positions in the record header byte.
  localparam int unsigned HDR_MB_BIT = 7;
  localparam int unsigned HDR_ME_BIT = 6;
  localparam int unsigned HDR_CF_BIT = 5;
  localparam int unsigned HDR_SR_BIT = 4;
  localparam int unsigned HDR_IL_BIT = 3;

  // Count of the last byte of a four-byte payload length.
  localparam logic [1:0] LEN_LAST_BYTE = 2'd3;

  // Result kinds.
  typedef enum logic [2:0] {
    KIND_DESC    = 3'd0,
    KIND_TYPE    = 3'd1,
    KIND_ID      = 3'd2,
    KIND_PAYLOAD = 3'd3,
    KIND_TRUNC   = 3'd4
  } kind_e;

  // Parser phases, one-hot.
  typedef enum logic [8:0] {
    PH_SKIP  = 9'b000000001,
    PH_HDR   = 9'b000000010,
    PH_TLEN  = 9'b000000100,
    PH_PLEN  = 9'b000001000,
    PH_IDLEN = 9'b000010000,
    PH_TYPE  = 9'b000100000,
    PH_ID    = 9'b001000000,
    PH_BODY  = 9'b010000000,
    PH_DONE  = 9'b100000000
  } phase_e;

  // One result item.
  typedef struct packed {
    kind_e       kind;
    logic [7:0]  content_byte;
    logic        flag_mb;
    logic        flag_me;
    logic        flag_cf;
    logic        flag_sr;
    logic        flag_il;
    logic [2:0]  name_format;
    logic [7:0]  type_len;
    logic [31:0] body_len;
    logic [7:0]  id_len;
    logic [7:0]  record_index;
  } res_t;

endpackage

// ===== hw/rtl/ndef_rsp_if.sv =====
// Valid/ready channel interfaces for the NDEF record stream parser.
// The input channel carries image bytes and the output channel carries results.
// The output channel interface depends on ndef_rsp_pkg.
interface ndef_rsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_byte;

  modport source (output valid, output in_byte, output last_byte, input ready);
  modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

interface ndef_rsp_out_if;
  import ndef_rsp_pkg::*;
  logic        valid;
  logic        ready;
  kind_e       kind;
  logic [7:0]  content_byte;
  logic        flag_mb;
  logic        flag_me;
  logic        flag_cf;
  logic        flag_sr;
  logic        flag_il;
  logic [2:0]  name_format;
  logic [7:0]  type_len;
  logic [31:0] body_len;
  logic [7:0]  id_len;
  logic [7:0]  record_index;

  modport source (
    output valid, output kind, output content_byte, output flag_mb, output flag_me,
    output flag_cf, output flag_sr, output flag_il, output name_format,
    output type_len, output body_len, output id_len, output record_index,
    input ready
  );
  modport sink (
    input valid, input kind, input content_byte, input flag_mb, input flag_me,
    input flag_cf, input flag_sr, input flag_il, input name_format,
    input type_len, input body_len, input id_len, input record_index,
    output ready
  );
endinterface

// ===== hw/rtl/ndef_rsp_parser.sv =====
// Parser state and per-byte update logic for the NDEF record stream parser.
// It takes one registered byte per step and produces at most one result.
// It depends on ndef_rsp_pkg.
module ndef_rsp_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          byte_i,
  input  logic                last_i,
  input  logic [3:0]          prefix_skip_i,
  output logic                res_valid_o,
  output ndef_rsp_pkg::res_t  res_o
);
  import ndef_rsp_pkg::*;

  // Section positions: where to look for the next nonempty section.
  localparam logic [1:0] SEC_TYPE = 2'd0;
  localparam logic [1:0] SEC_ID   = 2'd1;
  localparam logic [1:0] SEC_BODY = 2'd2;
  localparam logic [1:0] SEC_NONE = 2'd3;

  typedef struct packed {
    phase_e      ph;
    logic [31:0] rem;
    logic        ended;
  } sect_t;

  // Picks the first nonempty section at or after pos, or ends the record.
  function automatic sect_t next_sec(input logic [1:0]  pos,
                                     input logic [7:0]  tl,
                                     input logic [7:0]  il,
                                     input logic [31:0] bl,
                                     input logic        me);
    sect_t s;
    s.ph    = me ? PH_DONE : PH_HDR;
    s.rem   = '0;
    s.ended = 1'b0;
    if (pos == SEC_TYPE && tl != 8'd0) begin
      s.ph  = PH_TYPE;
      s.rem = {24'd0, tl};
    end else if (pos <= SEC_ID && il != 8'd0) begin
      s.ph  = PH_ID;
      s.rem = {24'd0, il};
    end else if (pos <= SEC_BODY && bl != 32'd0) begin
      s.ph  = PH_BODY;
      s.rem = bl;
    end else begin
      s.ended = 1'b1;
    end
    return s;
  endfunction

  phase_e      phase_q, phase_d;
  logic [3:0]  skip_q, skip_d;
  logic [7:0]  hdr_q, hdr_d;
  logic [7:0]  tlen_q, tlen_d;
  logic [31:0] blen_q, blen_d;
  logic [1:0]  lbc_q, lbc_d;
  logic [7:0]  idlen_q, idlen_d;
  logic [31:0] rem_q, rem_d;
  logic [7:0]  count_q, count_d;

  phase_e      ph;
  sect_t       sec;
  logic        take_sec;
  logic        len_done;
  logic [31:0] rem_dec;
  logic        res_vld;
  kind_e       kind;
  logic [7:0]  cbyte;

  // Next state and result for the byte in the input register.
  always_comb begin
    phase_d  = phase_q;
    skip_d   = skip_q;
    hdr_d    = hdr_q;
    tlen_d   = tlen_q;
    blen_d   = blen_q;
    lbc_d    = lbc_q;
    idlen_d  = idlen_q;
    rem_d    = rem_q;
    count_d  = count_q;
    sec      = '0;
    take_sec = 1'b0;
    len_done = 1'b0;
    rem_dec  = '0;
    res_vld  = 1'b0;
    kind     = KIND_DESC;
    cbyte    = 8'd0;

    // A finished prefix makes this byte the first record header.
    ph = phase_q;
    if (ph == PH_SKIP && skip_q >= prefix_skip_i) begin
      ph = PH_HDR;
    end
    phase_d = ph;

    case (ph)
      PH_SKIP: begin
        skip_d = skip_q + 4'd1;
      end
      PH_HDR: begin
        hdr_d   = byte_i;
        tlen_d  = 8'd0;
        blen_d  = 32'd0;
        lbc_d   = 2'd0;
        idlen_d = 8'd0;
        rem_d   = 32'd0;
        phase_d = PH_TLEN;
      end
      PH_TLEN: begin
        tlen_d  = byte_i;
        phase_d = PH_PLEN;
      end
      PH_PLEN: begin
        if (hdr_q[HDR_SR_BIT]) begin
          blen_d   = {24'd0, byte_i};
          len_done = 1'b1;
        end else begin
          blen_d = {blen_q[23:0], byte_i};
          if (lbc_q == LEN_LAST_BYTE) begin
            lbc_d    = 2'd0;
            len_done = 1'b1;
          end else begin
            lbc_d = lbc_q + 2'd1;
          end
        end
        if (len_done) begin
          if (hdr_q[HDR_IL_BIT]) begin
            phase_d = PH_IDLEN;
          end else begin
            res_vld  = 1'b1;
            kind     = KIND_DESC;
            sec      = next_sec(SEC_TYPE, tlen_q, idlen_q, blen_d, hdr_q[HDR_ME_BIT]);
            take_sec = 1'b1;
          end
        end
      end
      PH_IDLEN: begin
        idlen_d  = byte_i;
        res_vld  = 1'b1;
        kind     = KIND_DESC;
        sec      = next_sec(SEC_TYPE, tlen_q, byte_i, blen_q, hdr_q[HDR_ME_BIT]);
        take_sec = 1'b1;
      end
      PH_TYPE, PH_ID, PH_BODY: begin
        res_vld = 1'b1;
        cbyte   = byte_i;
        rem_dec = (rem_q != 32'd0) ? rem_q - 32'd1 : 32'd0;
        rem_d   = rem_dec;
        if (ph == PH_TYPE) begin
          kind = KIND_TYPE;
        end else if (ph == PH_ID) begin
          kind = KIND_ID;
        end else begin
          kind = KIND_PAYLOAD;
        end
        if (rem_dec == 32'd0) begin
          if (ph == PH_TYPE) begin
            sec = next_sec(SEC_ID, tlen_q, idlen_q, blen_q, hdr_q[HDR_ME_BIT]);
          end else if (ph == PH_ID) begin
            sec = next_sec(SEC_BODY, tlen_q, idlen_q, blen_q, hdr_q[HDR_ME_BIT]);
          end else begin
            sec = next_sec(SEC_NONE, tlen_q, idlen_q, blen_q, hdr_q[HDR_ME_BIT]);
          end
          take_sec = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // Section change or end of record; the record count saturates.
    if (take_sec) begin
      phase_d = sec.ph;
      rem_d   = sec.rem;
      if (sec.ended && count_q != 8'hFF) begin
        count_d = count_q + 8'd1;
      end
    end

    // The last byte inside an unfinished record reports a truncation.
    if (last_i && (phase_d inside {PH_TLEN, PH_PLEN, PH_IDLEN, PH_TYPE, PH_ID, PH_BODY})) begin
      res_vld = 1'b1;
      kind    = KIND_TRUNC;
      cbyte   = 8'd0;
    end

    res_valid_o        = res_vld;
    res_o.kind         = kind;
    res_o.content_byte = cbyte;
    res_o.flag_mb      = hdr_d[HDR_MB_BIT];
    res_o.flag_me      = hdr_d[HDR_ME_BIT];
    res_o.flag_cf      = hdr_d[HDR_CF_BIT];
    res_o.flag_sr      = hdr_d[HDR_SR_BIT];
    res_o.flag_il      = hdr_d[HDR_IL_BIT];
    res_o.name_format  = hdr_d[2:0];
    res_o.type_len     = tlen_d;
    res_o.body_len     = blen_d;
    res_o.id_len       = idlen_d;
    res_o.record_index = count_q;

    // The last byte returns the parser to its reset state.
    if (last_i) begin
      phase_d = PH_SKIP;
      skip_d  = 4'd0;
      hdr_d   = 8'd0;
      tlen_d  = 8'd0;
      blen_d  = 32'd0;
      lbc_d   = 2'd0;
      idlen_d = 8'd0;
      rem_d   = 32'd0;
      count_d = 8'd0;
    end
  end

  // Parser state registers, updated once per processed byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SKIP;
      skip_q  <= 4'd0;
      hdr_q   <= 8'd0;
      tlen_q  <= 8'd0;
      blen_q  <= 32'd0;
      lbc_q   <= 2'd0;
      idlen_q <= 8'd0;
      rem_q   <= 32'd0;
      count_q <= 8'd0;
    end else if (step_i) begin
      phase_q <= phase_d;
      skip_q  <= skip_d;
      hdr_q   <= hdr_d;
      tlen_q  <= tlen_d;
      blen_q  <= blen_d;
      lbc_q   <= lbc_d;
      idlen_q <= idlen_d;
      rem_q   <= rem_d;
      count_q <= count_d;
    end
  end

endmodule

// ===== hw/rtl/ndef_record_stream_parser.sv =====
// Top level of the NDEF record stream parser: input register, parser, result register.
// It depends on ndef_rsp_pkg, the channel interfaces and ndef_rsp_parser.
//
// The block takes one tag image byte per clock and gives at most one result per byte,
// so it sustains one byte per cycle while the sink keeps taking results. A byte waits in
// the input register until the result register is free; there the parser updates its
// state and forms the result, which then waits in the result register until the sink
// takes it. The result register frees in the same cycle it is taken. Prefix bytes,
// header bytes, length bytes other than the one that completes the lengths, and bytes
// after the message end give no result, but a last byte inside an unfinished record
// reports a truncation. The prefix skip count takes effect at the next skip check;
// write it between images.
module ndef_record_stream_parser (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  ndef_rsp_in_if.sink           in_i,
  ndef_rsp_out_if.source        out_o,
  input  logic                  cfg_we_i,
  input  logic [3:0]            cfg_wdata_i
);
  import ndef_rsp_pkg::*;

  logic [3:0] prefix_skip_q;
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       out_valid_q;
  res_t       out_q;
  logic       out_free;
  logic       step;
  logic       accept;
  logic       res_valid;
  res_t       res;

  // Prefix skip register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_skip_q <= PREFIX_SKIP_RST;
    end else if (cfg_we_i) begin
      prefix_skip_q <= cfg_wdata_i;
    end
  end

  // Handshake: a byte is processed when the result register can take its result.
  assign out_free   = !out_valid_q || out_o.ready;
  assign step       = in_valid_q && out_free;
  assign in_i.ready = !in_valid_q || out_free;
  assign accept     = in_i.valid && in_i.ready;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_byte_q <= in_i.in_byte;
      in_last_q <= in_i.last_byte;
    end
  end

  ndef_rsp_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .byte_i        (in_byte_q),
    .last_i        (in_last_q),
    .prefix_skip_i (prefix_skip_q),
    .res_valid_o   (res_valid),
    .res_o         (res)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res_valid) begin
      out_q <= res;
    end
  end

  // Output channel.
  assign out_o.valid        = out_valid_q;
  assign out_o.kind         = out_q.kind;
  assign out_o.content_byte = out_q.content_byte;
  assign out_o.flag_mb      = out_q.flag_mb;
  assign out_o.flag_me      = out_q.flag_me;
  assign out_o.flag_cf      = out_q.flag_cf;
  assign out_o.flag_sr      = out_q.flag_sr;
  assign out_o.flag_il      = out_q.flag_il;
  assign out_o.name_format  = out_q.name_format;
  assign out_o.type_len     = out_q.type_len;
  assign out_o.body_len     = out_q.body_len;
  assign out_o.id_len       = out_q.id_len;
  assign out_o.record_index = out_q.record_index;

endmodule

// ===== hw/rtl/ndef_rsp_checker.sv =====
// Port-level checks for the NDEF record stream parser, bound to its top level.
// It depends on ndef_rsp_pkg and on the top level ndef_record_stream_parser.
module ndef_rsp_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [2:0]  out_kind_i,
  input  logic [7:0]  out_content_byte_i,
  input  logic        out_flag_sr_i,
  input  logic        out_flag_il_i,
  input  logic [31:0] out_body_len_i,
  input  logic [7:0]  out_id_len_i
);
  import ndef_rsp_pkg::*;

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_content_byte_i)
      && $stable(out_kind_i) && $stable(out_body_len_i))
    else $error("result changed while stalled");

  // Descriptors and truncation reports carry no content byte.
  a_no_content: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_kind_i == KIND_DESC || out_kind_i == KIND_TRUNC)
      |-> out_content_byte_i == 8'd0)
    else $error("content byte set on descriptor or truncation");

  // The id length is only ever taken when the header says it is present.
  a_id_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_flag_il_i |-> out_id_len_i == 8'd0)
    else $error("id length without IL flag");

  // A short record has a one-byte payload length.
  a_short_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_flag_sr_i |-> out_body_len_i[31:8] == 24'd0)
    else $error("short record with long payload length");

endmodule

bind ndef_record_stream_parser ndef_rsp_checker u_ndef_rsp_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .out_valid_i        (out_o.valid),
  .out_ready_i        (out_o.ready),
  .out_kind_i         (out_o.kind),
  .out_content_byte_i (out_o.content_byte),
  .out_flag_sr_i      (out_o.flag_sr),
  .out_flag_il_i      (out_o.flag_il),
  .out_body_len_i     (out_o.body_len),
  .out_id_len_i       (out_o.id_len)
);
